// ----- hdl/necir_pkg.sv -----
`timescale 1ns / 1ps

package necir_pkg;

   localparam int STAMP_W  = 16;
   localparam int UNIT_W   = 11;
   localparam int TOL_W    = 10;
   localparam int STATUS_W = 3;
   localparam int WORD_W   = 16;
   localparam int BITS_W   = 6;
   localparam int COUNT_W  = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = UNIT_W;

   // Signed width for the timing bounds: the largest bound stays below 2^17.
   localparam int BOUND_W = 19;

   localparam logic [UNIT_W-1:0] UNIT_RESET = 11'd562;
   localparam logic [TOL_W-1:0]  TOL_RESET  = 10'd100;

   localparam logic [CSR_IDX_W-1:0] CSR_UNIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOL  = 1'd1;

   localparam logic [STATUS_W-1:0] ST_BUSY   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DONE   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_LONG   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_SHORT  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_INV    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_REPEAT = 3'd5;

   localparam logic [BITS_W-1:0] FRAME_BITS = 6'd32;
   localparam logic [BITS_W-1:0] HALF_BITS  = 6'd16;

   typedef struct packed {
      logic lead_long;
      logic lead_short;
      logic lead_repeat;
      logic bit_long;
      logic bit_short;
      logic bit_one;
   } bound_flags_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [WORD_W-1:0]   frame_word;
      logic [BITS_W-1:0]   bits_taken;
   } result_type;

endpackage

// ----- hdl/necir_bounds.sv -----
`timescale 1ns / 1ps

module necir_bounds (
   input  logic [necir_pkg::STAMP_W-1:0] interval,
   input  logic [necir_pkg::UNIT_W-1:0]  unit_ticks,
   input  logic [necir_pkg::TOL_W-1:0]   tolerance_ticks,
   output necir_pkg::bound_flags_type    flags
);
   import necir_pkg::*;

   logic signed [BOUND_W-1:0] t_s;
   logic signed [BOUND_W-1:0] u_s;
   logic signed [BOUND_W-1:0] e_s;
   logic signed [BOUND_W-1:0] hdr;

   assign t_s = signed'({{(BOUND_W-STAMP_W){1'b0}}, interval});
   assign u_s = signed'({{(BOUND_W-UNIT_W){1'b0}}, unit_ticks});
   assign e_s = signed'({{(BOUND_W-TOL_W){1'b0}}, tolerance_ticks});

   // Leader mark of 15.5 units, rounded down: 31u / 2.
   assign hdr = ((u_s <<< 5) - u_s) >>> 1;

   always_comb begin
      flags.bit_long    = t_s > ((u_s <<< 2) + e_s);
      flags.bit_short   = t_s < ((u_s <<< 1) - e_s);
      flags.bit_one     = t_s >= ((u_s <<< 2) - e_s);
      flags.lead_long   = t_s > (hdr + (u_s <<< 3) + (e_s <<< 3));
      flags.lead_short  = t_s < (hdr + (u_s <<< 2) - e_s);
      flags.lead_repeat = t_s < (hdr + (u_s <<< 3) - e_s);
   end

endmodule

// ----- hdl/necir_core.sv -----
`timescale 1ns / 1ps

module necir_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic [necir_pkg::STAMP_W-1:0] stamp,
   input  logic [necir_pkg::UNIT_W-1:0]  unit_ticks,
   input  logic [necir_pkg::TOL_W-1:0]   tolerance_ticks,
   output necir_pkg::result_type         result
);
   import necir_pkg::*;

   localparam logic [1:0] MODE_ARM  = 2'd0;
   localparam logic [1:0] MODE_LEAD = 2'd1;
   localparam logic [1:0] MODE_DATA = 2'd2;

   localparam logic [COUNT_W-1:0] CNT_ADDR     = 5'd7;
   localparam logic [COUNT_W-1:0] CNT_ADDR_INV = 5'd15;
   localparam logic [COUNT_W-1:0] CNT_CMD      = 5'd23;
   localparam logic [COUNT_W-1:0] CNT_CMD_INV  = 5'd31;

   logic [1:0]         mode_ff, mode_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [STAMP_W-1:0] last_stamp_ff;
   logic [WORD_W-1:0]  word_ff, word_in;
   logic [7:0]         shift_ff, shift_in;
   logic [STAMP_W-1:0] interval;
   logic [7:0]         shifted;
   logic [BITS_W-1:0]  next_bits;
   bound_flags_type    flags;

   assign interval  = stamp - last_stamp_ff;
   assign next_bits = {1'b0, count_ff} + 6'd1;

   necir_bounds u_bounds (
      .interval        (interval),
      .unit_ticks      (unit_ticks),
      .tolerance_ticks (tolerance_ticks),
      .flags           (flags)
   );

   assign shifted = {flags.bit_one, shift_ff[7:1]};

   always_comb begin
      mode_in           = mode_ff;
      count_in          = count_ff;
      word_in           = word_ff;
      shift_in          = shift_ff;
      result.status     = ST_BUSY;
      result.bits_taken = '0;
      case (mode_ff)
         MODE_DATA: begin
            if (flags.bit_long || flags.bit_short) begin
               result.status     = flags.bit_long ? ST_LONG : ST_SHORT;
               result.bits_taken = {1'b0, count_ff};
               mode_in           = MODE_LEAD;
               count_in          = '0;
            end else begin
               shift_in          = shifted;
               count_in          = count_ff + 5'd1;
               result.bits_taken = next_bits;
               case (count_ff)
                  CNT_ADDR: word_in = {shifted, 8'h00};
                  CNT_ADDR_INV: begin
                     if (~word_ff[15:8] != shifted) begin
                        result.status     = ST_INV;
                        result.bits_taken = HALF_BITS;
                        mode_in           = MODE_LEAD;
                        count_in          = '0;
                     end
                  end
                  CNT_CMD: word_in = word_ff | {8'h00, shifted};
                  CNT_CMD_INV: begin
                     result.bits_taken = FRAME_BITS;
                     count_in          = '0;
                     if (~word_ff[7:0] != shifted) begin
                        result.status = ST_INV;
                        mode_in       = MODE_LEAD;
                     end else begin
                        result.status = ST_DONE;
                        mode_in       = MODE_ARM;
                     end
                  end
                  default: ;
               endcase
            end
         end
         MODE_LEAD: begin
            count_in = '0;
            if (flags.lead_long) begin
               result.status = ST_LONG;
            end else if (flags.lead_short) begin
               result.status = ST_SHORT;
            end else if (flags.lead_repeat) begin
               result.status = ST_REPEAT;
            end else begin
               mode_in = MODE_DATA;
            end
         end
         default: begin
            mode_in  = MODE_LEAD;
            count_in = '0;
         end
      endcase
      result.frame_word = word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_ARM;
         count_ff      <= '0;
         last_stamp_ff <= '0;
         word_ff       <= '0;
         shift_ff      <= '0;
      end else if (fire) begin
         mode_ff       <= mode_in;
         count_ff      <= count_in;
         last_stamp_ff <= stamp;
         word_ff       <= word_in;
         shift_ff      <= shift_in;
      end
   end

endmodule

// ----- hdl/nec_ir_frame_decoder_unit.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// req       in         req_valid/stall     req_edge_stamp (timer stamp of one falling edge)
// rsp       out        rsp_valid/stall     rsp_status, rsp_frame_word, rsp_bits_taken
// csr       in         csr_write_en        csr_index, csr_write_data
//
// Each edge word is held in the input register and is then decoded into the
// result register; one word can be taken in every cycle while the result is not
// stalled.
// Synchronous reset restores the default timing registers and waits for a leader.
// A stalled result holds the pipeline; the input side stalls only when the
// input register is full and cannot move on.
module nec_ir_frame_decoder_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [necir_pkg::STAMP_W-1:0]    req_edge_stamp,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [necir_pkg::STATUS_W-1:0]   rsp_status,
   output logic [necir_pkg::WORD_W-1:0]     rsp_frame_word,
   output logic [necir_pkg::BITS_W-1:0]     rsp_bits_taken,
   input  logic                             csr_write_en,
   input  logic [necir_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [necir_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import necir_pkg::*;

   logic [UNIT_W-1:0]  unit_ff;
   logic [TOL_W-1:0]   tol_ff;
   logic               in_valid_ff;
   logic [STAMP_W-1:0] in_stamp_ff;
   logic               out_valid_ff;
   result_type         out_ff;
   result_type         result;
   logic               advance;
   logic               fire;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff <= UNIT_RESET;
         tol_ff  <= TOL_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_UNIT: unit_ff <= csr_write_data;
            CSR_TOL:  tol_ff  <= csr_write_data[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_stamp_ff <= req_edge_stamp;
      end
   end

   necir_core u_core (
      .clock           (clock),
      .reset           (reset),
      .fire            (fire),
      .stamp           (in_stamp_ff),
      .unit_ticks      (unit_ff),
      .tolerance_ticks (tol_ff),
      .result          (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= result;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = out_ff.status;
   assign rsp_frame_word = out_ff.frame_word;
   assign rsp_bits_taken = out_ff.bits_taken;

endmodule

// ----- hdl/necir_checker.sv -----
`timescale 1ns / 1ps

module necir_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [necir_pkg::STATUS_W-1:0]   rsp_status,
   input logic [necir_pkg::WORD_W-1:0]     rsp_frame_word,
   input logic [necir_pkg::BITS_W-1:0]     rsp_bits_taken
);
   import necir_pkg::*;

   // A stalled result word must stay put until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_frame_word) && $stable(rsp_bits_taken))
      else $error("result word changed while stalled");

   // A finished frame always reports the full 32 bits.
   a_done_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_DONE |-> rsp_bits_taken == FRAME_BITS)
      else $error("frame done without 32 bits");

   // A repeat code is only recognised at the end of a leader.
   a_repeat_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_REPEAT |-> rsp_bits_taken == '0)
      else $error("repeat code reported with data bits");

   // An inverse check fails only on the 16th or 32nd bit.
   a_inv_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_INV |->
         rsp_bits_taken == HALF_BITS || rsp_bits_taken == FRAME_BITS)
      else $error("inverse mismatch at an unexpected bit");

   a_bits_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bits_taken <= FRAME_BITS)
      else $error("bit count beyond a frame");

endmodule

bind nec_ir_frame_decoder_unit necir_checker u_necir_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import necir_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 10;
   localparam int RESULT_LATENCY = 4;

   localparam logic [6:0] PH_IDLE          = 7'd1;
   localparam logic [6:0] PH_LEADER        = 7'd2;
   localparam logic [6:0] PH_FIRST_BIT     = 7'd4;
   localparam logic [6:0] PH_STEP          = 7'd2;
   localparam logic [6:0] PH_ADDR_LAST     = 7'd18;
   localparam logic [6:0] PH_ADDR_INV_LAST = 7'd34;
   localparam logic [6:0] PH_CMD_LAST      = 7'd50;

   typedef enum int {
      FRAME_CLEAN,
      FRAME_BAD_ADDR,
      FRAME_BAD_CMD,
      FRAME_LONG_GAP,
      FRAME_SHORT_GAP,
      FRAME_REPEAT,
      FRAME_NOISE
   } frame_kind_type;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic [STAMP_W-1:0]    req_edge_stamp = '0;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [WORD_W-1:0]     rsp_frame_word;
   logic [BITS_W-1:0]     rsp_bits_taken;
   logic                  csr_write_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index      = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   // Decoder state as the testbench sees it, starting from the reset values.
   logic [6:0]         dec_phase      = PH_IDLE;
   logic [STAMP_W-1:0] dec_last_stamp = '0;
   logic [WORD_W-1:0]  dec_word       = '0;
   logic [7:0]         dec_shift      = '0;
   logic [UNIT_W-1:0]  cfg_unit       = UNIT_RESET;
   logic [TOL_W-1:0]   cfg_tol        = TOL_RESET;

   result_type         pending_decodes[$];
   result_type         want;
   logic [STAMP_W-1:0] tx_stamp      = '0;
   int                 fail_count    = 0;
   int                 edges_sent    = 0;
   int                 settings_used = 1;
   int                 status_hits[8];
   int                 calm_items    = 0;
   int                 stall_left    = 0;
   int                 calm_left     = 0;
   int                 stall_roll;
   int                 idle_cycles   = 0;

   nec_ir_frame_decoder_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_edge_stamp (req_edge_stamp),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_frame_word (rsp_frame_word),
      .rsp_bits_taken (rsp_bits_taken),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [BITS_W-1:0] phase_bits(input logic [6:0] p);
      if (p < PH_FIRST_BIT) return '0;
      return BITS_W'((p - PH_FIRST_BIT) >> 1);
   endfunction

   // Advances the decoder state by one falling edge and returns the word it reports.
   function automatic result_type decode_edge(input logic [STAMP_W-1:0] stamp);
      logic [STAMP_W-1:0] delta;
      int                 t, u, e, hdr;
      logic               settled;
      result_type         r;
      delta = stamp - dec_last_stamp;
      t = int'(delta);
      u = int'(cfg_unit);
      e = int'(cfg_tol);
      hdr = (31 * u) / 2;
      dec_last_stamp = stamp;
      r.status = ST_BUSY;
      r.bits_taken = '0;
      if (dec_phase >= PH_FIRST_BIT) begin
         r.bits_taken = phase_bits(dec_phase);
         settled = 1'b0;
         if (t > 4 * u + e) begin
            dec_phase = PH_LEADER;
            r.status = ST_LONG;
            settled = 1'b1;
         end else if (t < 2 * u - e) begin
            dec_phase = PH_LEADER;
            r.status = ST_SHORT;
            settled = 1'b1;
         end else begin
            dec_shift = {t >= 4 * u - e, dec_shift[7:1]};
            if (dec_phase == PH_ADDR_LAST) begin
               dec_word = {dec_shift, 8'h00};
            end else if (dec_phase == PH_ADDR_INV_LAST) begin
               if (~dec_word[15:8] != dec_shift) begin
                  dec_phase = PH_LEADER;
                  r.status = ST_INV;
                  r.bits_taken = HALF_BITS;
                  settled = 1'b1;
               end
            end else if (dec_phase == PH_CMD_LAST) begin
               dec_word[7:0] = dec_word[7:0] | dec_shift;
            end else if (dec_phase[3:0] == PH_LEADER[3:0]) begin
               // Last bit of the inverted command: the frame either completes or fails.
               settled = 1'b1;
               if (~dec_word[7:0] != dec_shift) begin
                  r.bits_taken = phase_bits(dec_phase) + 1'b1;
                  dec_phase = PH_LEADER;
                  r.status = ST_INV;
               end else begin
                  dec_phase = PH_IDLE;
                  r.status = ST_DONE;
                  r.bits_taken = FRAME_BITS;
               end
            end
         end
         if (!settled) begin
            dec_phase = dec_phase + PH_STEP;
            r.bits_taken = phase_bits(dec_phase);
         end
      end else if (dec_phase == PH_LEADER) begin
         if (t > hdr + 8 * u + 8 * e) begin
            r.status = ST_LONG;
         end else if (t < hdr + 4 * u - e) begin
            r.status = ST_SHORT;
         end else if (t < hdr + 8 * u - e) begin
            r.status = ST_REPEAT;
         end else begin
            dec_phase = PH_FIRST_BIT;
         end
      end else begin
         dec_phase = PH_LEADER;
      end
      r.frame_word = dec_word;
      return r;
   endfunction

   // Picks an interval in the range, often right on one of its edges.
   function automatic int pick_interval(input int lo, input int hi);
      int roll;
      if (lo < 0) lo = 0;
      if (hi > 65535) hi = 65535;
      if (hi <= lo) return lo;
      roll = $urandom_range(7, 0);
      if (roll == 0) return lo;
      if (roll == 1) return hi;
      return $urandom_range(hi, lo);
   endfunction

   function automatic int next_gap();
      int roll;
      if (calm_items > 0) begin
         calm_items--;
         return 0;
      end
      roll = $urandom_range(99, 0);
      if (roll < 3) begin
         calm_items = $urandom_range(60, 20);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(10, 4);
      return $urandom_range(60, 20);
   endfunction

   // Valid stays high after acceptance so that back-to-back words need no extra step.
   task automatic send_edge(input logic [STAMP_W-1:0] stamp);
      int gap;
      gap = next_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_edge_stamp <= stamp;
      do @(posedge clock); while (req_stall);
      pending_decodes.push_back(decode_edge(stamp));
      edges_sent++;
   endtask

   task automatic send_interval(input int interval);
      tx_stamp = tx_stamp + STAMP_W'(interval);
      send_edge(tx_stamp);
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_decodes.size() != 0);
      repeat (RESULT_LATENCY) @(posedge clock);
   endtask

   task automatic set_timing(input logic [UNIT_W-1:0] unit, input logic [TOL_W-1:0] tol);
      logic spare;
      wait_results_drained();
      spare = 1'($urandom_range(1, 0));
      csr_write_en <= 1'b1;
      csr_index <= CSR_UNIT;
      csr_write_data <= unit;
      @(posedge clock);
      // The top data bit lies beyond the tolerance register and must be dropped.
      csr_index <= CSR_TOL;
      csr_write_data <= {spare, tol};
      @(posedge clock);
      csr_write_en <= 1'b0;
      cfg_unit = unit;
      cfg_tol = tol;
      settings_used++;
   endtask

   task automatic send_frame(input logic [7:0] addr, input logic [7:0] cmd,
                             input frame_kind_type kind);
      logic [31:0] payload;
      int          u, e, hdr, bad_bit, i;
      u = int'(cfg_unit);
      e = int'(cfg_tol);
      hdr = (31 * u) / 2;
      payload = {~cmd, cmd, ~addr, addr};
      bad_bit = $urandom_range(31, 0);
      if (kind == FRAME_BAD_ADDR) payload[8 + $urandom_range(7, 0)] ^= 1'b1;
      if (kind == FRAME_BAD_CMD) payload[24 + $urandom_range(7, 0)] ^= 1'b1;
      send_interval($urandom_range(65535, 0));
      if (kind == FRAME_REPEAT) begin
         send_interval(pick_interval(hdr + 4 * u - e, hdr + 8 * u - e - 1));
      end else begin
         send_interval(pick_interval(hdr + 8 * u - e, hdr + 8 * u + 8 * e));
         for (i = 0; i < 32; i++) begin
            if ((kind == FRAME_LONG_GAP || kind == FRAME_SHORT_GAP) && i == bad_bit) begin
               if (kind == FRAME_SHORT_GAP && 2 * u - e > 0)
                  send_interval(pick_interval(0, 2 * u - e - 1));
               else
                  send_interval(pick_interval(4 * u + e + 1, 65535));
               break;
            end
            if (payload[i])
               send_interval(pick_interval(4 * u - e, 4 * u + e));
            else
               send_interval(pick_interval(2 * u - e, 4 * u - e - 1));
         end
      end
   endtask

   task automatic test_leader_and_bit_bounds();
      int u, e, hdr;
      u = int'(cfg_unit);
      e = int'(cfg_tol);
      hdr = (31 * u) / 2;
      send_interval(0);
      send_interval(65535);
      // A nominal leader whose stamp wraps past the top of the timer.
      send_interval(hdr + 8 * u);
      send_interval(2 * u - e - 1);
      send_interval(hdr + 4 * u - e);
      send_interval(hdr + 8 * u - e - 1);
      send_interval(hdr + 4 * u - e - 1);
      send_interval(hdr + 8 * u + 8 * e);
      send_interval(4 * u + e);
      send_interval(2 * u - e);
      send_interval(4 * u - e - 1);
      send_interval(4 * u - e);
      send_interval(4 * u + e + 1);
      send_interval(hdr + 8 * u + 8 * e + 1);
      send_interval(hdr + 8 * u - e);
      send_interval(0);
   endtask

   task automatic test_random_frames(input int sequences);
      int             n, k, roll;
      logic [7:0]     addr, cmd;
      frame_kind_type kind;
      for (n = 0; n < sequences; n++) begin
         addr = 8'($urandom_range(255, 0));
         cmd = 8'($urandom_range(255, 0));
         roll = $urandom_range(7, 0);
         if (roll == 0) begin
            addr = 8'h00;
            cmd = 8'hFF;
         end else if (roll == 1) begin
            addr = 8'hFF;
            cmd = 8'h00;
         end
         roll = $urandom_range(99, 0);
         if (roll < 60) kind = FRAME_CLEAN;
         else if (roll < 68) kind = FRAME_BAD_ADDR;
         else if (roll < 76) kind = FRAME_BAD_CMD;
         else if (roll < 84) kind = FRAME_LONG_GAP;
         else if (roll < 90) kind = FRAME_SHORT_GAP;
         else if (roll < 95) kind = FRAME_REPEAT;
         else kind = FRAME_NOISE;
         if (kind == FRAME_NOISE) begin
            for (k = $urandom_range(6, 1); k > 0; k--) send_interval($urandom_range(65535, 0));
         end else begin
            send_frame(addr, cmd, kind);
         end
         if ($urandom_range(4, 0) == 0) wait_results_drained();
      end
   endtask

   task automatic test_timing_extremes();
      set_timing(11'd1, 10'd0);
      test_random_frames(5);
      set_timing(11'd2047, 10'd1023);
      test_random_frames(5);
      set_timing(11'd1, 10'd1023);
      test_random_frames(5);
      set_timing(11'd2047, 10'd0);
      test_random_frames(5);
   endtask

   task automatic test_random_timing();
      int n;
      for (n = 0; n < 2; n++) begin
         set_timing(UNIT_W'($urandom_range(2047, 1)), TOL_W'($urandom_range(1023, 0)));
         test_random_frames(5);
      end
      set_timing(UNIT_RESET, TOL_RESET);
      test_random_frames(5);
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (calm_left > 0) begin
         calm_left <= calm_left - 1;
         rsp_stall <= 1'b0;
      end else begin
         stall_roll = $urandom_range(999, 0);
         if (stall_roll < 5) begin
            calm_left <= $urandom_range(200, 50);
            rsp_stall <= 1'b0;
         end else if (stall_roll < 20) begin
            stall_left <= $urandom_range(30, 6);
            rsp_stall <= 1'b1;
         end else if (stall_roll < 300) begin
            stall_left <= $urandom_range(2, 0);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_decodes.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("unexpected result word: status %0d frame_word %h bits_taken %0d",
                        rsp_status, rsp_frame_word, rsp_bits_taken);
         end else begin
            want = pending_decodes.pop_front();
            status_hits[want.status]++;
            if (rsp_status !== want.status || rsp_frame_word !== want.frame_word ||
                rsp_bits_taken !== want.bits_taken) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("mismatch: expected status %0d word %h bits %0d, got %0d %h %0d",
                           want.status, want.frame_word, want.bits_taken,
                           rsp_status, rsp_frame_word, rsp_bits_taken);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", pending_decodes.size());
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_leader_and_bit_bounds();
      test_random_frames(8);
      test_timing_extremes();
      test_random_timing();
      wait_results_drained();
      $display("Covered %0d edge words under %0d timing settings, register extremes included.",
               edges_sent, settings_used);
      $display("Reported %0d frames, %0d repeats, %0d long, %0d short, %0d inverse errors.",
               status_hits[ST_DONE], status_hits[ST_REPEAT], status_hits[ST_LONG],
               status_hits[ST_SHORT], status_hits[ST_INV]);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d failures", fail_count);
         $display("status: fail");
      end
      $finish;
   end

endmodule
